// ===== sv/asa_pkg.sv =====
package asa_pkg;

  localparam int unsigned BASE_W  = 40;
  localparam int unsigned POOL_W  = 32;
  localparam int unsigned SIZE_W  = 32;
  localparam int unsigned ALIGN_W = 32;
  localparam int unsigned ADDR_W  = 41;
  localparam int unsigned TOP_W   = 33;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned CFG_W   = 40;

  typedef enum logic [0:0] {
    CFG_REGION_BASE = 1'b0,
    CFG_POOL_SIZE   = 1'b1
  } cfg_index_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_OVERFLOW = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_MISMATCH = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  typedef enum logic [0:0] {
    MODE_ALLOC   = 1'b0,
    MODE_RELEASE = 1'b1
  } mode_t;

  // one port of a record memory
  typedef struct packed {
    logic        we;
    logic [TOP_W-1:0] wdata;
  } ram_wr_t;

endpackage

// ===== sv/asa_record_ram.sv =====
module asa_record_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic                clk,
  input  asa_pkg::ram_wr_t    wr,
  input  logic [AW-1:0]       waddr,
  input  logic [AW-1:0]       raddr,
  output logic [WIDTH-1:0]    rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[waddr] <= wr.wdata[WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/aligned_stack_allocator_unit.sv =====
// LIFO bump allocator over a pool at region_base of pool_size bytes. Each
// input beat (tuser[0]: 0 allocate, 1 release) yields exactly one result
// beat with the block address, a status code and the live record count.
// The accept cycle reads the newest record start and the previous record
// end from the two record memories and rounds the top offset to the
// alignment; the execute state, once the output register is free, checks,
// updates top and the record stack, and loads the output register. A new
// item is accepted in the cycle after execution, while the previous result
// may still wait in the output register. Failing items leave all state
// unchanged. The record memories need no clearing after reset.
module aligned_stack_allocator_unit #(
  parameter int unsigned MAX_RECORDS = 64,
  localparam int unsigned LIVE_W = $clog2(MAX_RECORDS + 1),
  localparam int unsigned OUT_W = ((asa_pkg::ADDR_W + asa_pkg::STAT_W + LIVE_W + 7) / 8) * 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [0:0]                 cfg_index,
  input  logic [asa_pkg::CFG_W-1:0]  cfg_data,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // request_size [31:0], request_alignment [63:32], release_address [104:64]
  input  logic [111:0]               s_axis_tdata,
  // mode [0]
  input  logic [0:0]                 s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // block_address [40:0], status [43:41], live_blocks [43+LIVE_W:44]
  output logic [OUT_W-1:0]           m_axis_tdata
);

  localparam int unsigned AW  = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
  localparam int unsigned PAD = OUT_W - asa_pkg::ADDR_W - asa_pkg::STAT_W - LIVE_W;
  localparam int unsigned TW  = asa_pkg::TOP_W;

  asa_pkg::state_t state;

  logic [asa_pkg::BASE_W-1:0] region_base;
  logic [asa_pkg::POOL_W-1:0] pool_size;
  logic [TW-1:0]              top_offset;
  logic [LIVE_W-1:0]          record_count;
  logic [LIVE_W-1:0]          record_count_next;

  logic                        mode_q;
  logic [asa_pkg::SIZE_W-1:0]  size_q;
  logic [TW-1:0]               aligned_q;
  logic [asa_pkg::ADDR_W-1:0]  addr_q;

  logic [asa_pkg::SIZE_W-1:0]  in_size;
  logic [asa_pkg::ALIGN_W-1:0] in_align;
  logic [asa_pkg::ADDR_W-1:0]  in_addr;
  logic [TW-1:0]               mask;
  logic [TW-1:0]               aligned;

  logic [TW:0]                 new_top;
  logic [asa_pkg::ADDR_W-1:0]  alloc_addr;
  logic [asa_pkg::ADDR_W-1:0]  cmp_addr;
  logic [asa_pkg::POOL_W-1:0]  start_rd;
  logic [TW-1:0]               end_rd;

  asa_pkg::ram_wr_t  ram_wr;
  logic [AW-1:0]     waddr;
  logic [AW-1:0]     raddr_start;
  logic [AW-1:0]     raddr_end;

  logic              in_fire;
  logic              exec_go;
  logic              do_push;
  logic              do_pop;
  asa_pkg::status_t  status;
  logic [asa_pkg::ADDR_W-1:0] result_addr;

  assign in_size  = s_axis_tdata[31:0];
  assign in_align = s_axis_tdata[63:32];
  assign in_addr  = s_axis_tdata[104:64];

  assign s_axis_tready = (state == asa_pkg::S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign exec_go       = (state == asa_pkg::S_EXEC) && (!m_axis_tvalid || m_axis_tready);

  assign mask    = {1'b0, in_align - asa_pkg::ALIGN_W'(1)};
  assign aligned = (top_offset + mask) & ~mask;

  assign new_top    = {1'b0, aligned_q} + (TW + 1)'(size_q);
  assign alloc_addr = asa_pkg::ADDR_W'(region_base) + asa_pkg::ADDR_W'(aligned_q);
  assign cmp_addr   = asa_pkg::ADDR_W'(region_base) + asa_pkg::ADDR_W'(start_rd);

  always_comb begin
    status            = asa_pkg::ST_OK;
    do_push           = 1'b0;
    do_pop            = 1'b0;
    result_addr       = '0;
    record_count_next = record_count;
    if (mode_q == asa_pkg::MODE_ALLOC) begin
      priority if (record_count >= LIVE_W'(MAX_RECORDS)) begin
        status = asa_pkg::ST_FULL;
      end else if (new_top > (TW + 1)'(pool_size)) begin
        status = asa_pkg::ST_OVERFLOW;
      end else begin
        do_push           = 1'b1;
        result_addr       = alloc_addr;
        record_count_next = record_count + LIVE_W'(1);
      end
    end else begin
      priority if (record_count == '0) begin
        status = asa_pkg::ST_EMPTY;
      end else if (cmp_addr != addr_q) begin
        status = asa_pkg::ST_MISMATCH;
      end else begin
        do_pop            = 1'b1;
        record_count_next = record_count - LIVE_W'(1);
      end
    end
  end

  assign waddr        = record_count[AW-1:0];
  assign raddr_start  = AW'(record_count - LIVE_W'(1));
  assign raddr_end    = AW'(record_count - LIVE_W'(2));
  assign ram_wr.we    = exec_go && do_push;
  assign ram_wr.wdata = aligned_q;

  asa_record_ram #(
    .WIDTH (asa_pkg::POOL_W),
    .DEPTH (MAX_RECORDS),
    .AW    (AW)
  ) u_start_ram (
    .clk   (clk),
    .wr    (ram_wr),
    .waddr (waddr),
    .raddr (raddr_start),
    .rdata (start_rd)
  );

  asa_pkg::ram_wr_t ram_wr_end;
  assign ram_wr_end.we    = ram_wr.we;
  assign ram_wr_end.wdata = new_top[TW-1:0];

  asa_record_ram #(
    .WIDTH (TW),
    .DEPTH (MAX_RECORDS),
    .AW    (AW)
  ) u_end_ram (
    .clk   (clk),
    .wr    (ram_wr_end),
    .waddr (waddr),
    .raddr (raddr_end),
    .rdata (end_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      region_base <= '0;
      pool_size   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        asa_pkg::CFG_REGION_BASE: region_base <= cfg_data;
        asa_pkg::CFG_POOL_SIZE:   pool_size   <= cfg_data[asa_pkg::POOL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      mode_q    <= s_axis_tuser[0];
      size_q    <= in_size;
      aligned_q <= aligned;
      addr_q    <= in_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= asa_pkg::S_IDLE;
      top_offset    <= '0;
      record_count  <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (exec_go) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        asa_pkg::S_IDLE: begin
          if (in_fire) begin
            state <= asa_pkg::S_EXEC;
          end
        end
        asa_pkg::S_EXEC: begin
          if (exec_go) begin
            state         <= asa_pkg::S_IDLE;
            record_count  <= record_count_next;
            if (do_push) begin
              top_offset <= new_top[TW-1:0];
            end else if (do_pop) begin
              top_offset <= (record_count == LIVE_W'(1)) ? '0 : end_rd;
            end
          end
        end
        default: state <= asa_pkg::S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      m_axis_tdata <= {{PAD{1'b0}}, record_count_next, status, result_addr};
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    record_count <= LIVE_W'(MAX_RECORDS))
    else $error("record count beyond capacity");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (state == asa_pkg::S_EXEC) && !s_axis_tready)
    else $error("accepted beat did not start execution");

  a_count_quiet: assert property (@(posedge clk) disable iff (rst)
    (state != asa_pkg::S_EXEC) |=> $stable(record_count) && $stable(top_offset))
    else $error("stack state changed outside execution");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    ram_wr.we |-> record_count < LIVE_W'(MAX_RECORDS))
    else $error("record push into full stack");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam logic [6:0] MAX_LIVE    = 7'd64;
  localparam int         DIR_ROWS    = 24;
  localparam int         DIR_WIDE_AT = 5;
  localparam int         PHASES      = 6;
  localparam int         PHASE_ITEMS = 140;
  localparam int         CALM_PHASE  = 2;
  localparam int         CHOKE_PHASE = 3;
  localparam int         CHOKE_LEN   = 400;
  localparam int         STALL_LIMIT = 3000;
  localparam int         GAP_PCT     = 17;

  typedef struct packed {
    logic [40:0]      addr;
    asa_pkg::status_t status;
    logic [6:0]       live;
  } alloc_result_t;

  typedef struct {
    asa_pkg::mode_t   mode;
    logic [31:0]      size;
    logic [31:0]      align;
    logic [40:0]      addr;
    bit               from_newest;
    bit               fixed;
    logic [40:0]      exp_addr;
    asa_pkg::status_t exp_status;
    logic [6:0]       exp_live;
  } dir_row_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [39:0] cfg_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // request_size [31:0], request_alignment [63:32], release_address [104:64]
  logic [111:0] s_axis_tdata;
  // mode [0]
  logic [0:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // block_address [40:0], status [43:41], live_blocks [50:44]
  logic [55:0] m_axis_tdata;

  aligned_stack_allocator_unit uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // allocator shadow state
  logic [39:0] region_base_q = '0;
  logic [31:0] pool_bytes    = '0;
  logic [32:0] top_off       = '0;
  logic [6:0]  live_cnt      = '0;
  logic [31:0] blk_start [64];
  logic [32:0] blk_end   [64];

  alloc_result_t pending_results [$];
  alloc_result_t want_r;
  int          mismatches  = 0;
  bit          calm        = 1'b0;
  int          choke_asks  = 0;
  int          choke_done  = 0;
  int          idle_cycles = 0;

  function automatic logic [40:0] newest_block_addr();
    logic [63:0] sum;
    sum = '0;
    if (live_cnt != 0)
      sum = {24'd0, region_base_q} + {32'd0, blk_start[live_cnt[5:0] - 6'd1]};
    return sum[40:0];
  endfunction

  function automatic alloc_result_t alloc_predict(asa_pkg::mode_t m, logic [31:0] sz,
                                                  logic [31:0] al, logic [40:0] ra);
    alloc_result_t r;
    logic [63:0]   mask;
    logic [63:0]   aligned;
    logic [63:0]   new_top;
    logic [63:0]   sum;
    r.addr   = '0;
    r.status = asa_pkg::ST_OK;
    if (m == asa_pkg::MODE_ALLOC) begin
      mask    = {32'd0, al - 32'd1};
      aligned = ({31'd0, top_off} + mask) & ~mask;
      new_top = aligned + {32'd0, sz};
      if (live_cnt >= MAX_LIVE) begin
        r.status = asa_pkg::ST_FULL;
      end else if (new_top > {32'd0, pool_bytes}) begin
        r.status = asa_pkg::ST_OVERFLOW;
      end else begin
        blk_start[live_cnt[5:0]] = aligned[31:0];
        blk_end[live_cnt[5:0]]   = new_top[32:0];
        live_cnt = live_cnt + 7'd1;
        top_off  = new_top[32:0];
        sum      = {24'd0, region_base_q} + aligned;
        r.addr   = sum[40:0];
      end
    end else if (live_cnt == 0) begin
      r.status = asa_pkg::ST_EMPTY;
    end else if (newest_block_addr() != ra) begin
      r.status = asa_pkg::ST_MISMATCH;
    end else begin
      live_cnt = live_cnt - 7'd1;
      top_off  = (live_cnt == 0) ? 33'd0 : blk_end[live_cnt[5:0] - 6'd1];
    end
    r.live = live_cnt;
    return r;
  endfunction

  task automatic issue_request(input asa_pkg::mode_t m, input logic [31:0] sz,
                               input logic [31:0] al,
                               input logic [40:0] ra, input bit fixed,
                               input alloc_result_t want);
    alloc_result_t r;
    while (!calm && $urandom_range(0, 99) < GAP_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, ra, al, sz};
    s_axis_tuser  <= m;
    do @(posedge clk); while (!s_axis_tready);
    r = alloc_predict(m, sz, al, ra);
    pending_results.push_back(fixed ? want : r);
    @(negedge clk);
  endtask

  task automatic program_pool(input logic [39:0] base, input logic [31:0] pool);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= asa_pkg::CFG_REGION_BASE;
    cfg_data  <= base;
    @(negedge clk);
    region_base_q = base;
    cfg_index <= asa_pkg::CFG_POOL_SIZE;
    cfg_data  <= {8'd0, pool};
    @(negedge clk);
    pool_bytes = pool;
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    dir_row_t       dir_tab [DIR_ROWS];
    logic [39:0]    ph_base [PHASES];
    logic [31:0]    ph_pool [PHASES];
    int             ph_pct  [PHASES];
    logic [63:0]    wide;
    logic [40:0]    ra;
    logic [31:0]    sz;
    logic [31:0]    al;
    asa_pkg::mode_t m;
    alloc_result_t  want;
    int             sel;

    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = asa_pkg::CFG_REGION_BASE;
    cfg_data      = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = asa_pkg::MODE_ALLOC;

    dir_tab = '{
      // reset config: base 0, pool 0
      '{asa_pkg::MODE_RELEASE, 32'd0, 32'd1, 41'd0, 1'b0, 1'b1,
        41'd0, asa_pkg::ST_EMPTY, 7'd0},
      '{asa_pkg::MODE_ALLOC, 32'd0, 32'd1, 41'd0, 1'b0, 1'b1,
        41'd0, asa_pkg::ST_OK, 7'd1},
      '{asa_pkg::MODE_ALLOC, 32'd1, 32'd1, 41'd0, 1'b0, 1'b1,
        41'd0, asa_pkg::ST_OVERFLOW, 7'd1},
      '{asa_pkg::MODE_RELEASE, 32'd0, 32'd1, 41'h1FF_FFFF_FFFF, 1'b0, 1'b1,
        41'd0, asa_pkg::ST_MISMATCH, 7'd1},
      '{asa_pkg::MODE_RELEASE, 32'd0, 32'd1, 41'd0, 1'b0, 1'b1,
        41'd0, asa_pkg::ST_OK, 7'd0},
      // base and pool at maximum
      '{asa_pkg::MODE_ALLOC, 32'hFFFF_FFFF, 32'd1, 41'd0, 1'b0, 1'b1,
        41'h0FF_FFFF_FFFF, asa_pkg::ST_OK, 7'd1},
      '{asa_pkg::MODE_ALLOC, 32'd0, 32'h8000_0000, 41'd0, 1'b0, 1'b1,
        41'd0, asa_pkg::ST_OVERFLOW, 7'd1},
      '{asa_pkg::MODE_ALLOC, 32'd0, 32'd0, 41'd0, 1'b0, 1'b1,
        41'd0, asa_pkg::ST_OVERFLOW, 7'd1},
      '{asa_pkg::MODE_RELEASE, 32'd0, 32'd1, 41'd0, 1'b0, 1'b1,
        41'd0, asa_pkg::ST_MISMATCH, 7'd1},
      '{asa_pkg::MODE_RELEASE, 32'd0, 32'd1, 41'd0, 1'b1, 1'b1,
        41'd0, asa_pkg::ST_OK, 7'd0},
      '{asa_pkg::MODE_ALLOC, 32'd3, 32'd1, 41'd0, 1'b0, 1'b1,
        41'h0FF_FFFF_FFFF, asa_pkg::ST_OK, 7'd1},
      '{asa_pkg::MODE_ALLOC, 32'd5, 32'd3, 41'd0, 1'b0, 1'b0,
        41'd0, asa_pkg::ST_OK, 7'd0},
      '{asa_pkg::MODE_ALLOC, 32'd0, 32'h8000_0000, 41'd0, 1'b0, 1'b0,
        41'd0, asa_pkg::ST_OK, 7'd0},
      '{asa_pkg::MODE_ALLOC, 32'd16, 32'd16, 41'd0, 1'b0, 1'b0,
        41'd0, asa_pkg::ST_OK, 7'd0},
      '{asa_pkg::MODE_RELEASE, 32'd0, 32'd1, 41'd1, 1'b1, 1'b0,
        41'd0, asa_pkg::ST_OK, 7'd0},
      '{asa_pkg::MODE_RELEASE, 32'd0, 32'd1, 41'd0, 1'b1, 1'b0,
        41'd0, asa_pkg::ST_OK, 7'd0},
      '{asa_pkg::MODE_RELEASE, 32'd0, 32'd1, 41'd0, 1'b1, 1'b0,
        41'd0, asa_pkg::ST_OK, 7'd0},
      '{asa_pkg::MODE_ALLOC, 32'd0, 32'd0, 41'd0, 1'b0, 1'b0,
        41'd0, asa_pkg::ST_OK, 7'd0},
      '{asa_pkg::MODE_ALLOC, 32'd7, 32'd8, 41'd0, 1'b0, 1'b0,
        41'd0, asa_pkg::ST_OK, 7'd0},
      '{asa_pkg::MODE_RELEASE, 32'd0, 32'd1, 41'h100_0000_0000, 1'b1, 1'b0,
        41'd0, asa_pkg::ST_OK, 7'd0},
      '{asa_pkg::MODE_RELEASE, 32'd0, 32'd1, 41'd0, 1'b1, 1'b0,
        41'd0, asa_pkg::ST_OK, 7'd0},
      '{asa_pkg::MODE_RELEASE, 32'd0, 32'd1, 41'd0, 1'b1, 1'b0,
        41'd0, asa_pkg::ST_OK, 7'd0},
      '{asa_pkg::MODE_RELEASE, 32'd0, 32'd1, 41'd0, 1'b1, 1'b0,
        41'd0, asa_pkg::ST_OK, 7'd0},
      '{asa_pkg::MODE_RELEASE, 32'd0, 32'd1, 41'd0, 1'b0, 1'b1,
        41'd0, asa_pkg::ST_EMPTY, 7'd0}
    };

    wide = {$urandom, $urandom};
    ph_base[0] = wide[39:0];          ph_pool[0] = 32'hFFFF_FFFF; ph_pct[0] = 85;
    ph_base[1] = 40'd0;               ph_pool[1] = 32'd4096;      ph_pct[1] = 55;
    ph_base[2] = 40'hFF_FFFF_F000;    ph_pool[2] = 32'h0010_0000; ph_pct[2] = 50;
    wide = {$urandom, $urandom};
    ph_base[3] = wide[39:0];          ph_pool[3] = $urandom;      ph_pct[3] = 60;
    ph_base[4] = 40'hFF_FFFF_FFFF;    ph_pool[4] = 32'hFFFF_FFFF; ph_pct[4] = 85;
    ph_base[5] = 40'd1;               ph_pool[5] = 32'd0;         ph_pct[5] = 45;

    repeat (8) @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (i == DIR_WIDE_AT) program_pool(40'hFF_FFFF_FFFF, 32'hFFFF_FFFF);
      ra = dir_tab[i].from_newest ? (newest_block_addr() ^ dir_tab[i].addr) : dir_tab[i].addr;
      want.addr   = dir_tab[i].exp_addr;
      want.status = dir_tab[i].exp_status;
      want.live   = dir_tab[i].exp_live;
      issue_request(dir_tab[i].mode, dir_tab[i].size, dir_tab[i].align, ra,
                    dir_tab[i].fixed, want);
    end

    for (int p = 0; p < PHASES; p++) begin
      program_pool(ph_base[p], ph_pool[p]);
      calm = (p == CALM_PHASE);
      if (p == CHOKE_PHASE) choke_asks++;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        m = ($urandom_range(0, 99) < ph_pct[p]) ? asa_pkg::MODE_ALLOC : asa_pkg::MODE_RELEASE;

        sel = $urandom_range(0, 99);
        if (sel < 60)      sz = $urandom_range(0, 64);
        else if (sel < 85) sz = $urandom_range(0, 4095);
        else if (sel < 95) sz = $urandom;
        else if (sel < 98) sz = 32'd0;
        else               sz = 32'hFFFF_FFFF;

        sel = $urandom_range(0, 99);
        if (sel < 70)      al = 32'd1 << $urandom_range(0, 6);
        else if (sel < 88) al = 32'd1 << $urandom_range(0, 31);
        else if (sel < 96) al = $urandom;
        else               al = 32'd0;

        sel  = $urandom_range(0, 99);
        wide = {$urandom, $urandom};
        if (m == asa_pkg::MODE_RELEASE && live_cnt != 0 && sel < 85)
          ra = newest_block_addr();
        else if (m == asa_pkg::MODE_RELEASE && sel < 93)
          ra = newest_block_addr() ^ (41'd1 << $urandom_range(0, 40));
        else
          ra = wide[40:0];

        want = '0;
        issue_request(m, sz, al, ra, 1'b0, want);
      end
      calm = 1'b0;
    end

    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (mismatches == 0) begin
      $display("aligned_stack_allocator_unit: match");
    end else begin
      $display("aligned_stack_allocator_unit: mismatch");
    end
    $finish;
  end

  // result sink: random backpressure (none in the calm phase) plus one long hold-off
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (choke_asks != choke_done) begin
        m_axis_tready <= 1'b0;
        repeat (CHOKE_LEN) @(negedge clk);
        choke_done++;
      end else begin
        m_axis_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= GAP_PCT);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing pending: %h", m_axis_tdata);
        mismatches++;
      end else begin
        want_r = pending_results.pop_front();
        if (m_axis_tdata[40:0] != want_r.addr) begin
          $error("block_address: expected %h, got %h", want_r.addr, m_axis_tdata[40:0]);
          mismatches++;
        end
        if (m_axis_tdata[43:41] != want_r.status) begin
          $error("status: expected %0d, got %0d", want_r.status, m_axis_tdata[43:41]);
          mismatches++;
        end
        if (m_axis_tdata[50:44] != want_r.live) begin
          $error("live_blocks: expected %0d, got %0d", want_r.live, m_axis_tdata[50:44]);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("aligned_stack_allocator_unit: mismatch");
        $finish;
      end
    end
  end

endmodule

// ===== files.f =====
sv/asa_pkg.sv
sv/asa_record_ram.sv
sv/aligned_stack_allocator_unit.sv
tb/tb.sv
